@@ hw/rtl/lras_pkg.sv @@
// shared types and constants for the lazy range-add range-sum tree
`default_nettype none

package lras_pkg;

    localparam int ACT_W   = 2;
    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int SIZE_W  = 11;
    localparam int CNT_W   = 11;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_SUM   = 2'd1,
        ACT_POINT = 2'd2,
        ACT_CLEAR = 2'd3
    } t_act;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_DEC, ST_PU_RD, ST_PU_CHK, ST_OP_MUL, ST_OP_WR,
        ST_WK_L, ST_WK_R, ST_WK_SH, ST_RB_CHK, ST_RB_0, ST_RB_1, ST_RB_2,
        ST_RB_3, ST_RB_4, ST_DONE, ST_CL_LEAF, ST_CL_0, ST_CL_1, ST_CL_2
    } t_state;

    typedef enum logic [2:0] {
        PH_PT, PH_SUML, PH_SUMR, PH_WALKS, PH_WALKA, PH_RBL, PH_RBR
    } t_phase;

    typedef enum logic [1:0] {
        RET_PUSH0, RET_PUSH1, RET_WL, RET_WR
    } t_ret;

    typedef enum logic [2:0] {
        RES_ERR, RES_ZERO, RES_ADD, RES_ACC, RES_RD
    } t_res;

    typedef enum logic [3:0] {
        A_HOLD, A_PUSH, A_DBL, A_NEXT, A_L, A_R1, A_TGT,
        A_N2, A_N21, A_NODE, A_C2, A_C21
    } t_asel;

    typedef enum logic [2:0] {
        W_NONE, W_INIT, W_LEAF, W_INNER, W_PUT, W_PZERO, W_RB
    } t_wr;

    typedef struct packed {
        t_asel asel;
        t_wr   wr;
        t_res  res;
        logic  load;
        logic  decode;
        logic  s_load;
        logic  s_dec;
        logic  tgt_r1;
        logic  pv_load;
        logic  use_pv;
        logic  prod_put;
        logic  prod_rb;
        logic  tmp_first;
        logic  tmp_add;
        logic  tmpc_load;
        logic  acc_add;
        logic  inc_l;
        logic  dec_r;
        logic  shift_lr;
        logic  node_l0;
        logic  node_r1;
        logic  node_up;
        logic  cntr_n;
        logic  cntr_inc;
        logic  cntr_nm1;
        logic  cntr_dec;
        logic  res_load;
    } t_cmd;

    typedef struct packed {
        t_act act;
        logic bad;
        logic empty;
        logic pt_bad;
        logic s_zero;
        logic p_zero;
        logic pend_nz;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic node_gt1;
        logic init_last;
        logic leaf_last;
        logic inner_done;
        logic n_one;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/lras_ctrl.sv @@
// sequencer for tree walks, pushes, rebuilds and clear sweeps
`default_nettype none

module lras_ctrl
    import lras_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_st, n_st;
    t_phase r_ph, n_ph;
    t_ret   r_ret, n_ret;
    t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_INIT;
            r_ph  <= PH_PT;
            r_ret <= RET_PUSH0;
            r_res <= RES_ZERO;
        end else begin
            r_st  <= n_st;
            r_ph  <= n_ph;
            r_ret <= n_ret;
            r_res <= n_res;
        end
    end

    assign o_in_stall = (r_st != ST_IDLE);

    // next state
    always_comb begin
        n_st  = r_st;
        n_ph  = r_ph;
        n_ret = r_ret;
        n_res = r_res;
        unique case (r_st)
            ST_INIT: if (i_stat.init_last) n_st = ST_IDLE;
            ST_IDLE: if (i_in_valid) n_st = ST_DEC;
            ST_DEC: begin
                unique case (i_stat.act)
                    ACT_CLEAR: n_st = ST_CL_LEAF;
                    ACT_POINT: begin
                        if (i_stat.pt_bad) begin
                            n_res = RES_ERR;
                            n_st  = ST_DONE;
                        end else begin
                            n_ph = PH_PT;
                            n_st = ST_PU_RD;
                        end
                    end
                    ACT_ADD, ACT_SUM: begin
                        priority if (i_stat.bad) begin
                            n_res = RES_ERR;
                            n_st  = ST_DONE;
                        end else if (i_stat.empty) begin
                            n_res = RES_ZERO;
                            n_st  = ST_DONE;
                        end else if (i_stat.act == ACT_ADD) begin
                            n_ph = PH_WALKA;
                            n_st = ST_WK_L;
                        end else begin
                            n_ph = PH_SUML;
                            n_st = ST_PU_RD;
                        end
                    end
                    default: n_st = ST_IDLE;
                endcase
            end
            ST_PU_RD: begin
                priority if (i_stat.s_zero) begin
                    priority case (r_ph)
                        PH_PT: begin
                            n_res = RES_RD;
                            n_st  = ST_DONE;
                        end
                        PH_SUML: n_ph = PH_SUMR;
                        default: begin
                            n_ph = PH_WALKS;
                            n_st = ST_WK_L;
                        end
                    endcase
                end else if (!i_stat.p_zero) begin
                    n_st = ST_PU_CHK;
                end
            end
            ST_PU_CHK: begin
                if (i_stat.pend_nz) begin
                    n_ret = RET_PUSH0;
                    n_st  = ST_OP_MUL;
                end else begin
                    n_st = ST_PU_RD;
                end
            end
            ST_OP_MUL: begin
                if (r_ph == PH_WALKS) begin
                    n_st = (r_ret == RET_WL) ? ST_WK_R : ST_WK_SH;
                end else begin
                    n_st = ST_OP_WR;
                end
            end
            ST_OP_WR: begin
                unique case (r_ret)
                    RET_PUSH0: begin
                        n_ret = RET_PUSH1;
                        n_st  = ST_OP_MUL;
                    end
                    RET_PUSH1: n_st = ST_PU_RD;
                    RET_WL:    n_st = ST_WK_R;
                    RET_WR:    n_st = ST_WK_SH;
                    default:   n_st = ST_PU_RD;
                endcase
            end
            ST_WK_L: begin
                priority if (!i_stat.l_lt_r) begin
                    if (r_ph == PH_WALKA) begin
                        n_ph = PH_RBL;
                        n_st = ST_RB_CHK;
                    end else begin
                        n_res = RES_ACC;
                        n_st  = ST_DONE;
                    end
                end else if (i_stat.l_odd) begin
                    n_ret = RET_WL;
                    n_st  = ST_OP_MUL;
                end else begin
                    n_st = ST_WK_R;
                end
            end
            ST_WK_R: begin
                if (i_stat.r_odd) begin
                    n_ret = RET_WR;
                    n_st  = ST_OP_MUL;
                end else begin
                    n_st = ST_WK_SH;
                end
            end
            ST_WK_SH: n_st = ST_WK_L;
            ST_RB_CHK: begin
                priority if (i_stat.node_gt1) begin
                    n_st = ST_RB_0;
                end else if (r_ph == PH_RBL) begin
                    n_ph = PH_RBR;
                end else begin
                    n_res = RES_ADD;
                    n_st  = ST_DONE;
                end
            end
            ST_RB_0: n_st = ST_RB_1;
            ST_RB_1: n_st = ST_RB_2;
            ST_RB_2: n_st = ST_RB_3;
            ST_RB_3: n_st = ST_RB_4;
            ST_RB_4: n_st = ST_RB_CHK;
            ST_DONE: if (i_stat.out_free) n_st = ST_IDLE;
            ST_CL_LEAF: begin
                if (i_stat.leaf_last) n_st = i_stat.n_one ? ST_IDLE : ST_CL_0;
            end
            ST_CL_0: n_st = ST_CL_1;
            ST_CL_1: n_st = ST_CL_2;
            ST_CL_2: n_st = i_stat.inner_done ? ST_IDLE : ST_CL_0;
            default: n_st = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.asel   = A_HOLD;
        o_cmd.wr     = W_NONE;
        o_cmd.res    = r_res;
        o_cmd.use_pv = (r_ph != PH_WALKA);
        unique case (r_st)
            ST_INIT: begin
                o_cmd.wr       = W_INIT;
                o_cmd.cntr_inc = 1'b1;
            end
            ST_IDLE: o_cmd.load = i_in_valid;
            ST_DEC: begin
                o_cmd.decode = 1'b1;
                o_cmd.s_load = 1'b1;
                o_cmd.cntr_n = 1'b1;
            end
            ST_PU_RD: begin
                priority if (i_stat.s_zero) begin
                    priority case (r_ph)
                        PH_PT:   o_cmd.asel = A_TGT;
                        PH_SUML: begin
                            o_cmd.tgt_r1 = 1'b1;
                            o_cmd.s_load = 1'b1;
                        end
                        default: o_cmd.asel = A_HOLD;
                    endcase
                end else if (i_stat.p_zero) begin
                    o_cmd.s_dec = 1'b1;
                end else begin
                    o_cmd.asel = A_PUSH;
                end
            end
            ST_PU_CHK: begin
                if (i_stat.pend_nz) begin
                    o_cmd.pv_load = 1'b1;
                    o_cmd.wr      = W_PZERO;
                    o_cmd.asel    = A_DBL;
                end else begin
                    o_cmd.s_dec = 1'b1;
                end
            end
            ST_OP_MUL: begin
                if (r_ph == PH_WALKS) begin
                    o_cmd.acc_add = 1'b1;
                    o_cmd.inc_l   = (r_ret == RET_WL);
                end else begin
                    o_cmd.prod_put = 1'b1;
                end
            end
            ST_OP_WR: begin
                o_cmd.wr = W_PUT;
                unique case (r_ret)
                    RET_PUSH0: o_cmd.asel  = A_NEXT;
                    RET_PUSH1: o_cmd.s_dec = 1'b1;
                    RET_WL:    o_cmd.inc_l = 1'b1;
                    RET_WR:    o_cmd.asel  = A_HOLD;
                    default:   o_cmd.asel  = A_HOLD;
                endcase
            end
            ST_WK_L: begin
                priority if (!i_stat.l_lt_r) begin
                    o_cmd.node_l0 = (r_ph == PH_WALKA);
                end else if (i_stat.l_odd) begin
                    o_cmd.asel = A_L;
                end
            end
            ST_WK_R: begin
                if (i_stat.r_odd) begin
                    o_cmd.asel  = A_R1;
                    o_cmd.dec_r = 1'b1;
                end
            end
            ST_WK_SH: o_cmd.shift_lr = 1'b1;
            ST_RB_CHK: begin
                priority if (i_stat.node_gt1) begin
                    o_cmd.node_up = 1'b1;
                end else if (r_ph == PH_RBL) begin
                    o_cmd.node_r1 = 1'b1;
                end
            end
            ST_RB_0: o_cmd.asel = A_N2;
            ST_RB_1: begin
                o_cmd.asel      = A_N21;
                o_cmd.tmp_first = 1'b1;
            end
            ST_RB_2: begin
                o_cmd.asel    = A_NODE;
                o_cmd.tmp_add = 1'b1;
            end
            ST_RB_3: o_cmd.prod_rb = 1'b1;
            ST_RB_4: o_cmd.wr = W_RB;
            ST_DONE: o_cmd.res_load = i_stat.out_free;
            ST_CL_LEAF: begin
                o_cmd.wr = W_LEAF;
                if (i_stat.leaf_last) o_cmd.cntr_nm1 = 1'b1;
                else o_cmd.cntr_inc = 1'b1;
            end
            ST_CL_0: o_cmd.asel = A_C2;
            ST_CL_1: begin
                o_cmd.asel      = A_C21;
                o_cmd.tmpc_load = 1'b1;
            end
            ST_CL_2: begin
                o_cmd.wr       = W_INNER;
                o_cmd.cntr_dec = 1'b1;
            end
            default: o_cmd.asel = A_HOLD;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/lras_dp.sv @@
// tree memories, walk registers, multiply-add and result register
`default_nettype none

module lras_dp
    import lras_pkg::*;
#(
    parameter int MAX_LEAVES  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic [SIZE_W-1:0]   i_size,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [START_W-1:0]  i_range_start,
    input  wire logic [END_W-1:0]    i_range_end,
    input  wire logic signed [DATA_W-1:0] i_add_value,
    input  wire logic                i_out_stall,
    output logic                     o_out_valid,
    output logic signed [DATA_W-1:0] o_sum,
    output logic [CNT_W-1:0]         o_element_count,
    output logic                     o_range_error
);

    localparam int NW  = $clog2(MAX_LEAVES) + 1;
    localparam int NDW = NW + 1;
    localparam int PW  = $clog2(MAX_LEAVES);
    localparam int SW  = $clog2(NW + 2);
    localparam int VW  = VALUE_WIDTH;

    logic [VW-1:0]    m_sum  [2*MAX_LEAVES];
    logic [CNT_W-1:0] m_cnt  [2*MAX_LEAVES];
    logic [VW-1:0]    m_pend [MAX_LEAVES];

    logic [ACT_W-1:0]   r_act;
    logic [START_W-1:0] r_lin;
    logic [END_W-1:0]   r_rin;
    logic [VW-1:0]      r_val;
    logic [NW-1:0]      r_n;
    logic [SW-1:0]      r_s;
    logic [NDW-1:0]     r_l, r_r, r_l0, r_r0, r_tgt, r_node;
    logic [NW-1:0]      r_cntr, r_raddr;
    logic [VW-1:0]      rd_sum, rd_pend;
    logic [CNT_W-1:0]   rd_cnt;
    logic [VW-1:0]      r_pv, r_prod, r_tmp, r_acc;
    logic [CNT_W-1:0]   r_tmpc, r_acnt;
    logic               r_ovalid;
    logic [DATA_W-1:0]  r_osum;
    logic [CNT_W-1:0]   r_ocnt;
    logic               r_oerr;

    logic [NW-1:0]    ra, wa;
    logic [PW-1:0]    pa;
    logic             we_s, we_c, we_p;
    logic [VW-1:0]    ws, wp, opv;
    logic [CNT_W-1:0] wc;
    logic [SW-1:0]    h;
    logic [NW-1:0]    n_lv;
    logic signed [63:0] v64;
    logic [63:0]        acc64, rd64;

    function automatic logic [SW-1:0] bitlen(input logic [NW-1:0] x);
        logic [SW-1:0] b;
        b = '0;
        for (int i = 0; i < NW; i++) begin
            if (x[i]) b = SW'(i + 1);
        end
        return b;
    endfunction

    // leaf count from the size register, clamped to the tree
    always_comb begin
        if (i_size == '0) n_lv = NW'(1);
        else if (32'(i_size) > MAX_LEAVES) n_lv = NW'(MAX_LEAVES);
        else n_lv = NW'(i_size);
    end

    assign v64   = 64'(i_add_value);
    assign h     = bitlen(r_n) + SW'(1);
    assign opv   = i_cmd.use_pv ? r_pv : r_val;
    assign acc64 = 64'(r_acc);
    assign rd64  = 64'(rd_sum);

    always_comb begin
        unique case (i_cmd.asel)
            A_HOLD:  ra = r_raddr;
            A_PUSH:  ra = NW'(r_tgt >> r_s);
            A_DBL:   ra = NW'({r_raddr, 1'b0});
            A_NEXT:  ra = r_raddr + NW'(1);
            A_L:     ra = NW'(r_l);
            A_R1:    ra = NW'(r_r - NDW'(1));
            A_TGT:   ra = NW'(r_tgt);
            A_N2:    ra = NW'({r_node, 1'b0});
            A_N21:   ra = NW'({r_node, 1'b1});
            A_NODE:  ra = NW'(r_node);
            A_C2:    ra = NW'({r_cntr, 1'b0});
            A_C21:   ra = NW'({r_cntr, 1'b1});
            default: ra = r_raddr;
        endcase
    end

    always_comb begin
        we_s = 1'b0;
        we_c = 1'b0;
        we_p = 1'b0;
        wa   = r_raddr;
        pa   = r_raddr[PW-1:0];
        ws   = '0;
        wc   = '0;
        wp   = '0;
        unique case (i_cmd.wr)
            W_NONE: we_s = 1'b0;
            W_INIT: begin
                wa   = r_cntr;
                pa   = r_cntr[PW-1:0];
                we_s = 1'b1;
                we_c = 1'b1;
                we_p = (32'(r_cntr) < MAX_LEAVES);
            end
            W_LEAF: begin
                wa   = r_cntr;
                we_s = 1'b1;
                we_c = 1'b1;
                wc   = CNT_W'(1);
            end
            W_INNER: begin
                wa   = r_cntr;
                pa   = r_cntr[PW-1:0];
                we_s = 1'b1;
                we_c = 1'b1;
                we_p = 1'b1;
                wc   = r_tmpc + rd_cnt;
            end
            W_PUT: begin
                we_s = 1'b1;
                ws   = rd_sum + r_prod;
                // only inner nodes carry a pending add
                we_p = (r_raddr < r_n);
                wp   = rd_pend + opv;
            end
            W_PZERO: we_p = 1'b1;
            W_RB: begin
                we_s = 1'b1;
                ws   = r_tmp + r_prod;
            end
            default: we_s = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_s) m_sum[wa] <= ws;
        rd_sum <= m_sum[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_c) m_cnt[wa] <= wc;
        rd_cnt <= m_cnt[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_p) m_pend[pa] <= wp;
        rd_pend <= m_pend[ra[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= ra;
        if (i_cmd.load) begin
            r_act <= i_action;
            r_lin <= i_range_start;
            r_rin <= i_range_end;
            r_val <= v64[VW-1:0];
            r_n   <= n_lv;
        end
        if (i_cmd.decode) begin
            r_l    <= NDW'(r_lin) + NDW'(r_n);
            r_l0   <= NDW'(r_lin) + NDW'(r_n);
            r_tgt  <= NDW'(r_lin) + NDW'(r_n);
            r_r    <= NDW'(r_rin) + NDW'(r_n);
            r_r0   <= NDW'(r_rin) + NDW'(r_n);
            r_acc  <= '0;
            r_acnt <= '0;
        end
        if (i_cmd.tgt_r1) r_tgt <= r_r0 - NDW'(1);
        if (i_cmd.s_load) r_s <= h;
        else if (i_cmd.s_dec) r_s <= r_s - SW'(1);
        if (i_cmd.pv_load) r_pv <= rd_pend;
        if (i_cmd.prod_put) r_prod <= VW'(rd_cnt) * opv;
        else if (i_cmd.prod_rb) r_prod <= VW'(rd_cnt) * rd_pend;
        if (i_cmd.tmp_first) r_tmp <= rd_sum;
        else if (i_cmd.tmp_add) r_tmp <= r_tmp + rd_sum;
        if (i_cmd.tmpc_load) r_tmpc <= rd_cnt;
        if (i_cmd.acc_add) begin
            r_acc  <= r_acc + rd_sum;
            r_acnt <= r_acnt + rd_cnt;
        end
        priority if (i_cmd.shift_lr) begin
            r_l <= r_l >> 1;
            r_r <= r_r >> 1;
        end else if (i_cmd.inc_l) begin
            r_l <= r_l + NDW'(1);
        end else if (i_cmd.dec_r) begin
            r_r <= r_r - NDW'(1);
        end
        priority if (i_cmd.node_l0) r_node <= r_l0;
        else if (i_cmd.node_r1) r_node <= r_r0 - NDW'(1);
        else if (i_cmd.node_up) r_node <= r_node >> 1;
        if (i_cmd.res_load) begin
            unique case (i_cmd.res)
                RES_ERR: begin
                    r_osum <= '0;
                    r_ocnt <= '0;
                    r_oerr <= 1'b1;
                end
                RES_ZERO: begin
                    r_osum <= '0;
                    r_ocnt <= '0;
                    r_oerr <= 1'b0;
                end
                RES_ADD: begin
                    r_osum <= '0;
                    r_ocnt <= CNT_W'(r_rin - END_W'(r_lin));
                    r_oerr <= 1'b0;
                end
                RES_ACC: begin
                    r_osum <= acc64[DATA_W-1:0];
                    r_ocnt <= r_acnt;
                    r_oerr <= 1'b0;
                end
                RES_RD: begin
                    r_osum <= rd64[DATA_W-1:0];
                    r_ocnt <= rd_cnt;
                    r_oerr <= 1'b0;
                end
                default: begin
                    r_osum <= '0;
                    r_ocnt <= '0;
                    r_oerr <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cntr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            priority if (i_cmd.cntr_n) r_cntr <= r_n;
            else if (i_cmd.cntr_nm1) r_cntr <= r_n - NW'(1);
            else if (i_cmd.cntr_inc) r_cntr <= r_cntr + NW'(1);
            else if (i_cmd.cntr_dec) r_cntr <= r_cntr - NW'(1);
            if (i_cmd.res_load) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.act        = t_act'(r_act);
        o_stat.bad        = (32'(r_lin) > 32'(r_rin)) || (32'(r_rin) > 32'(r_n));
        o_stat.empty      = (32'(r_lin) == 32'(r_rin));
        o_stat.pt_bad     = (32'(r_lin) >= 32'(r_n));
        o_stat.s_zero     = (r_s == '0);
        o_stat.p_zero     = ((r_tgt >> r_s) == '0);
        o_stat.pend_nz    = (rd_pend != '0);
        o_stat.l_lt_r     = (r_l < r_r);
        o_stat.l_odd      = r_l[0];
        o_stat.r_odd      = r_r[0];
        o_stat.node_gt1   = (r_node > NDW'(1));
        o_stat.init_last  = (32'(r_cntr) == 2 * MAX_LEAVES - 1);
        o_stat.leaf_last  = (32'(r_cntr) == 2 * 32'(r_n) - 1);
        o_stat.inner_done = (r_cntr == NW'(1));
        o_stat.n_one      = (r_n == NW'(1));
        o_stat.out_free   = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid     = r_ovalid;
    assign o_sum           = r_osum;
    assign o_element_count = r_ocnt;
    assign o_range_error   = r_oerr;

endmodule

`default_nettype wire

@@ hw/rtl/lazy_range_add_range_sum_core.sv @@
// one item in flight: accept, decode, the tree steps, then load the result
// add: walks the levels, updates each covering node, then rebuilds the ancestors on each end path
// sum, point read: pending adds on each end path are pushed down from the root, level by level;
// sum then walks the levels and accumulates each covering node; clear: leaves, then inner nodes
// reset: synchronous, then a sweep over all 2*MAX_LEAVES nodes zeroes the tree before input is taken
// a finished result waits in the output register while the next item is taken
`default_nettype none

module lazy_range_add_range_sum_core
    import lras_pkg::*;
#(
    parameter int MAX_LEAVES  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [SIZE_W-1:0]        i_cfg_wr_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic [START_W-1:0]       i_range_start,
    input  wire logic [END_W-1:0]         i_range_end,
    input  wire logic signed [DATA_W-1:0] i_add_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_sum,
    output logic [CNT_W-1:0]              o_element_count,
    output logic                          o_range_error
);

    logic [SIZE_W-1:0] r_size;
    t_cmd              cmd;
    t_stat             stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 11'd1024;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    lras_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lras_dp #(
        .MAX_LEAVES  (MAX_LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_size          (r_size),
        .i_action        (i_action),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_add_value     (i_add_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_sum           (o_sum),
        .o_element_count (o_element_count),
        .o_range_error   (o_range_error)
    );

endmodule

`default_nettype wire
